/* rtl/dns_question_extractor_core_defines.svh */
// Assertion macros shared by the DNS question extractor RTL.
// Depends on nothing; the including module must have clk and rst in scope.
`ifndef DNS_QUESTION_EXTRACTOR_CORE_DEFINES_SVH
`define DNS_QUESTION_EXTRACTOR_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DQE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define DQE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* rtl/dqe_pkg.sv */
// Shared types and constants for the DNS question extractor.
// Used by the interfaces and all RTL modules; depends on nothing.
package dqe_pkg;

  localparam int POSITION_BITS = 16;
  localparam int CMP_W = (POSITION_BITS > 9) ? POSITION_BITS : 9;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam int CFG_INDEX_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_IPV4_OFFSET = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_IPV6_OFFSET = CFG_INDEX_W'(1);

  localparam logic [7:0] IPV4_OFFSET_RESET = 8'd28;
  localparam logic [7:0] IPV6_OFFSET_RESET = 8'd48;
  localparam logic [8:0] DNS_HEADER_BYTES  = 9'd12;
  localparam logic [7:0] DOT_CHAR          = 8'h2e;
  localparam logic [3:0] IPV4_VERSION      = 4'd4;

  localparam logic [1:0] KIND_ADDR    = 2'd0;
  localparam logic [1:0] KIND_NAME    = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_SHORT = 2'd1;
  localparam logic [1:0] STATUS_TRUNC = 2'd2;

  // Everything one accepted byte produces: an optional address or name
  // result, and an optional packet summary.
  typedef struct packed {
    logic        has_data;
    logic        data_is_name;
    logic [7:0]  data_val;
    logic        has_sum;
    logic [15:0] qtype;
    logic [1:0]  status;
    logic        is_ipv6;
  } entry_t;

endpackage

/* rtl/dqe_if.sv */
// Channel interfaces of the DNS question extractor: packet bytes,
// results and configuration writes. Depends on dqe_pkg.
interface dqe_pkt_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  modport source (output valid, data_byte, last_byte, input ready);
  modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface dqe_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  value;
  logic [15:0] qtype;
  logic [1:0]  status;
  logic        is_ipv6;
  logic        packet_done;
  modport source (output valid, kind, value, qtype, status, is_ipv6, packet_done,
                  input ready);
  modport sink (input valid, kind, value, qtype, status, is_ipv6, packet_done,
                output ready);
endinterface

interface dqe_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [dqe_pkg::CFG_INDEX_W-1:0] index;
  logic [7:0]                      data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/dqe_front.sv */
// Front end: accepts packet bytes, tracks the parse state and classifies
// each byte into queue entries. Depends on dqe_pkg and dqe_if.
module dqe_front (
  input  logic              clk,
  input  logic              rst,
  dqe_pkt_if.sink           pkt,
  input  logic [7:0]        ipv4_offset,
  input  logic [7:0]        ipv6_offset,
  input  logic              q_full,
  output logic              push,
  output dqe_pkg::entry_t   entry
);

  localparam logic [2:0] PH_SKIP  = 3'd0;
  localparam logic [2:0] PH_LEN   = 3'd1;
  localparam logic [2:0] PH_LABEL = 3'd2;
  localparam logic [2:0] PH_TYPE  = 3'd3;
  localparam logic [2:0] PH_DONE  = 3'd4;

  localparam logic [dqe_pkg::POSITION_BITS-1:0] POS_MAX = '1;

  logic [dqe_pkg::POSITION_BITS-1:0] byte_position, byte_position_next;
  logic                              ip_is_v6, ip_is_v6_next;
  logic [2:0]                        parse_phase, parse_phase_next;
  logic [7:0]                        label_remaining, label_remaining_next;
  logic                              first_label, first_label_next;
  logic [15:0]                       type_accum, type_accum_next;
  logic [1:0]                        type_seen, type_seen_next;

  logic       accept;
  logic       v6;
  logic       addr_hit;
  logic [8:0] start;
  logic [2:0] phase_cur;
  logic [7:0] b;
  logic [7:0] label_dec;
  logic [1:0] type_inc;

  assign pkt.ready = !q_full;
  assign accept    = pkt.valid && pkt.ready;
  assign b         = pkt.data_byte;

  always_comb begin
    v6 = (byte_position == '0) ? (b[7:4] != dqe_pkg::IPV4_VERSION) : ip_is_v6;
    if (v6) begin
      addr_hit = (byte_position >= dqe_pkg::POSITION_BITS'(8)) &&
                 (byte_position < dqe_pkg::POSITION_BITS'(24));
    end else begin
      addr_hit = (byte_position >= dqe_pkg::POSITION_BITS'(12)) &&
                 (byte_position < dqe_pkg::POSITION_BITS'(16));
    end
    start = {1'b0, (v6 ? ipv6_offset : ipv4_offset)} + dqe_pkg::DNS_HEADER_BYTES;
    phase_cur = parse_phase;
    if (parse_phase == PH_SKIP &&
        dqe_pkg::CMP_W'(byte_position) >= dqe_pkg::CMP_W'(start)) begin
      phase_cur = PH_LEN;
    end

    label_dec = label_remaining - 8'd1;
    type_inc  = type_seen + 2'd1;

    entry              = '0;
    entry.is_ipv6      = v6;
    entry.has_data     = addr_hit;
    entry.data_is_name = 1'b0;
    entry.data_val     = b;

    parse_phase_next     = phase_cur;
    label_remaining_next = label_remaining;
    first_label_next     = first_label;
    type_accum_next      = type_accum;
    type_seen_next       = type_seen;

    case (phase_cur)
      PH_LEN: begin
        if (b == 8'd0) begin
          parse_phase_next = PH_TYPE;
          type_seen_next   = 2'd0;
          type_accum_next  = 16'd0;
        end else begin
          // A dot goes before every label but the first.
          if (!first_label && !addr_hit) begin
            entry.has_data     = 1'b1;
            entry.data_is_name = 1'b1;
            entry.data_val     = dqe_pkg::DOT_CHAR;
          end
          first_label_next     = 1'b0;
          label_remaining_next = b;
          parse_phase_next     = PH_LABEL;
        end
      end
      PH_LABEL: begin
        if (!addr_hit) begin
          entry.has_data     = 1'b1;
          entry.data_is_name = 1'b1;
        end
        label_remaining_next = label_dec;
        if (label_dec == 8'd0) begin
          parse_phase_next = PH_LEN;
        end
      end
      PH_TYPE: begin
        type_accum_next = {type_accum[7:0], b};
        type_seen_next  = type_inc;
        if (type_inc >= 2'd2) begin
          parse_phase_next = PH_DONE;
        end
      end
      default: begin
      end
    endcase

    entry.has_sum = pkt.last_byte;
    if (parse_phase_next == PH_SKIP) begin
      entry.status = dqe_pkg::STATUS_SHORT;
    end else if (parse_phase_next == PH_DONE) begin
      entry.status = dqe_pkg::STATUS_OK;
      entry.qtype  = type_accum_next;
    end else begin
      entry.status = dqe_pkg::STATUS_TRUNC;
    end

    byte_position_next = (byte_position < POS_MAX) ? byte_position + 1'b1 : byte_position;
    ip_is_v6_next      = v6;
  end

  assign push = accept && (entry.has_data || entry.has_sum);

  always_ff @(posedge clk) begin
    if (rst || (accept && pkt.last_byte)) begin
      byte_position   <= '0;
      ip_is_v6        <= 1'b0;
      parse_phase     <= PH_SKIP;
      label_remaining <= 8'd0;
      first_label     <= 1'b1;
      type_accum      <= 16'd0;
      type_seen       <= 2'd0;
    end else if (accept) begin
      byte_position   <= byte_position_next;
      ip_is_v6        <= ip_is_v6_next;
      parse_phase     <= parse_phase_next;
      label_remaining <= label_remaining_next;
      first_label     <= first_label_next;
      type_accum      <= type_accum_next;
      type_seen       <= type_seen_next;
    end
  end

endmodule

/* rtl/dqe_queue.sv */
// Short queue of classified entries between the front and back ends.
// Depends on dqe_pkg.
module dqe_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  dqe_pkg::entry_t push_entry,
  output logic            full,
  input  logic            pop,
  output logic            head_valid,
  output dqe_pkg::entry_t head
);

  dqe_pkg::entry_t                mem [dqe_pkg::QUEUE_DEPTH];
  logic [dqe_pkg::QPTR_W-1:0]     wr_ptr;
  logic [dqe_pkg::QPTR_W-1:0]     rd_ptr;
  logic [dqe_pkg::QCNT_W-1:0]     count;
  logic                           do_pop;

  assign full       = (count == dqe_pkg::QCNT_W'(dqe_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head       = mem[rd_ptr];
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push && !full, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/dqe_back.sv */
// Back end: drains queue entries and presents one result per transfer
// from an output register. Depends on dqe_pkg and dqe_if.
module dqe_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  dqe_pkg::entry_t head,
  output logic            pop,
  dqe_res_if.source       res
);

  logic        out_valid;
  logic [1:0]  out_kind;
  logic [7:0]  out_value;
  logic [15:0] out_qtype;
  logic [1:0]  out_status;
  logic        out_ipv6;
  logic        out_done;
  logic        data_sent;
  logic        load;
  logic        send_data;

  assign load      = head_valid && (!out_valid || res.ready);
  assign send_data = head.has_data && !data_sent;
  // An entry with both a data and a summary result is popped after the second.
  assign pop       = load && !(send_data && head.has_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      data_sent <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        data_sent <= send_data && head.has_sum;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_ipv6 <= head.is_ipv6;
      if (send_data) begin
        out_kind   <= head.data_is_name ? dqe_pkg::KIND_NAME : dqe_pkg::KIND_ADDR;
        out_value  <= head.data_val;
        out_qtype  <= 16'd0;
        out_status <= dqe_pkg::STATUS_OK;
        out_done   <= 1'b0;
      end else begin
        out_kind   <= dqe_pkg::KIND_SUMMARY;
        out_value  <= 8'd0;
        out_qtype  <= head.qtype;
        out_status <= head.status;
        out_done   <= 1'b1;
      end
    end
  end

  assign res.valid       = out_valid;
  assign res.kind        = out_kind;
  assign res.value       = out_value;
  assign res.qtype       = out_qtype;
  assign res.status      = out_status;
  assign res.is_ipv6     = out_ipv6;
  assign res.packet_done = out_done;

endmodule

/* rtl/dns_question_extractor_core.sv */
// Top level of the DNS question extractor: configuration registers,
// front end, entry queue and back end. Depends on dqe_pkg, dqe_if and
// the defines header.
//
// Usage: packet bytes arrive on pkt (data_byte, last_byte) with valid/ready;
// one byte is taken per cycle while the entry queue has room. Each byte
// yields zero, one or two results on res: a server-address byte, a name
// character (dots between labels), and on the last byte a summary with the
// query type and status. Results leave in order from an output register.
// A byte's results pass through the entry queue and then the output register.
// Each result takes its own transfer on the single result port, so bytes with
// two results hold back the sustained rate of one byte per cycle.
// When res stalls, the four-entry queue fills and pkt.ready drops; nothing
// is lost. cfg writes are always ready; index 0 sets the IPv4 payload offset
// and index 1 the IPv6 one, other indexes are ignored. Reset restores
// offsets 28 and 48, empties the queue and starts a fresh packet.
`include "dns_question_extractor_core_defines.svh"

module dns_question_extractor_core (
  input  logic      clk,
  input  logic      rst,
  dqe_pkt_if.sink   pkt,
  dqe_res_if.source res,
  dqe_cfg_if.sink   cfg
);

  logic [7:0]      ipv4_offset;
  logic [7:0]      ipv6_offset;
  logic            q_full;
  logic            push;
  dqe_pkg::entry_t push_entry;
  logic            pop;
  logic            head_valid;
  dqe_pkg::entry_t head;
  logic            res_data;
  logic            res_sum;
  logic            data_fields_clear;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ipv4_offset <= dqe_pkg::IPV4_OFFSET_RESET;
      ipv6_offset <= dqe_pkg::IPV6_OFFSET_RESET;
    end else if (cfg.valid && cfg.ready) begin
      case (cfg.index)
        dqe_pkg::REG_IPV4_OFFSET: ipv4_offset <= cfg.data;
        dqe_pkg::REG_IPV6_OFFSET: ipv6_offset <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  dqe_front u_front (
    .clk         (clk),
    .rst         (rst),
    .pkt         (pkt),
    .ipv4_offset (ipv4_offset),
    .ipv6_offset (ipv6_offset),
    .q_full      (q_full),
    .push        (push),
    .entry       (push_entry)
  );

  dqe_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  dqe_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .res        (res)
  );

  assign res_data          = res.valid && res.kind != dqe_pkg::KIND_SUMMARY;
  assign res_sum           = res.valid && res.kind == dqe_pkg::KIND_SUMMARY;
  assign data_fields_clear = !res.packet_done && res.qtype == 16'd0 &&
                             res.status == dqe_pkg::STATUS_OK;

  `DQE_ASSERT_SAME(a_data_clean, res_data, data_fields_clear)
  `DQE_ASSERT_SAME(a_sum_fields, res_sum, res.packet_done && res.value == 8'd0)
  `DQE_ASSERT_SAME(a_bad_no_type, res_sum && res.status != dqe_pkg::STATUS_OK, res.qtype == 16'd0)
  `DQE_ASSERT_NEXT(a_full_blocks, q_full && !pop, !pkt.ready)

endmodule

/* tb/dns_question_extractor_core_tb.sv */
// Self-checking testbench for dns_question_extractor_core: drives packet bytes and
// offset register writes, predicts every address, name and summary result in step.
// Depends on dqe_pkg, the dqe_*_if interfaces and the core RTL.
`timescale 1ns / 1ps

module dns_question_extractor_core_tb;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int RANDOM_ITEMS  = 120;
  localparam int REPORT_MAX    = 10;
  localparam logic [dqe_pkg::POSITION_BITS-1:0] POS_MAX = '1;

  localparam logic [2:0] PH_HDR_SKIP   = 3'd0;
  localparam logic [2:0] PH_LABEL_LEN  = 3'd1;
  localparam logic [2:0] PH_LABEL_BODY = 3'd2;
  localparam logic [2:0] PH_QTYPE      = 3'd3;
  localparam logic [2:0] PH_TRAILER    = 3'd4;

  localparam logic [dqe_pkg::CFG_INDEX_W-1:0] REG_SPARE = dqe_pkg::CFG_INDEX_W'(2);
  localparam logic [dqe_pkg::CFG_INDEX_W-1:0] REG_TOP   = '1;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  value;
    logic [15:0] qtype;
    logic [1:0]  status;
    logic        is_ipv6;
    logic        packet_done;
  } dns_result_t;

  logic clk;
  logic rst = 1'b1;

  dqe_pkt_if pkt_ch ();
  dqe_res_if res_ch ();
  dqe_cfg_if cfg_ch ();

  dns_question_extractor_core uut (
    .clk (clk),
    .rst (rst),
    .pkt (pkt_ch),
    .res (res_ch),
    .cfg (cfg_ch)
  );

  // Predictor state: a private copy of the offsets and the per-packet parser.
  logic [7:0]                        cfg_off4;
  logic [7:0]                        cfg_off6;
  logic [dqe_pkg::POSITION_BITS-1:0] pos_cnt;
  logic                              ipv6_mode;
  logic [2:0]                        phase;
  logic [7:0]                        label_left;
  logic                              first_label;
  logic [15:0]                       qtype_acc;
  logic [1:0]                        qtype_cnt;

  dns_result_t pending_results[$];
  logic [7:0]  pkt_buf[$];

  int   fail_count = 0;
  int   cycle_count = 0;
  logic idling_on = 1'b1;
  logic hold_req = 1'b0;
  logic pkt_offering = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    if ($urandom_range(0, 15) < 12) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [7:0] pick_offset();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 48));
  endfunction

  task automatic clear_packet();
    pos_cnt     = '0;
    ipv6_mode   = 1'b0;
    phase       = PH_HDR_SKIP;
    label_left  = 8'h00;
    first_label = 1'b1;
    qtype_acc   = 16'h0000;
    qtype_cnt   = 2'd0;
  endtask

  // Works out the results that one accepted byte causes.
  task automatic predict_extract(input logic [7:0] b, input logic is_last);
    logic [dqe_pkg::POSITION_BITS-1:0] p;
    logic [8:0]  start;
    logic        have;
    logic [1:0]  dkind;
    logic [7:0]  dval;
    logic [1:0]  st;
    logic [15:0] qt;
    p     = pos_cnt;
    have  = 1'b0;
    dkind = dqe_pkg::KIND_ADDR;
    dval  = 8'h00;
    if (p == 0) ipv6_mode = (b[7:4] != dqe_pkg::IPV4_VERSION);
    if (ipv6_mode ? (p >= 8 && p < 24) : (p >= 12 && p < 16)) begin
      have = 1'b1;
      dval = b;
    end
    start = {1'b0, (ipv6_mode ? cfg_off6 : cfg_off4)} + dqe_pkg::DNS_HEADER_BYTES;
    if (phase == PH_HDR_SKIP && p >= start) phase = PH_LABEL_LEN;
    // An address byte that is also a question byte still moves the parser,
    // but only its address result goes out.
    case (phase)
      PH_LABEL_LEN: begin
        if (b == 8'h00) begin
          phase     = PH_QTYPE;
          qtype_cnt = 2'd0;
          qtype_acc = 16'h0000;
        end else begin
          if (!first_label && !have) begin
            have  = 1'b1;
            dkind = dqe_pkg::KIND_NAME;
            dval  = dqe_pkg::DOT_CHAR;
          end
          first_label = 1'b0;
          label_left  = b;
          phase       = PH_LABEL_BODY;
        end
      end
      PH_LABEL_BODY: begin
        if (!have) begin
          have  = 1'b1;
          dkind = dqe_pkg::KIND_NAME;
          dval  = b;
        end
        label_left = label_left - 8'd1;
        if (label_left == 8'h00) phase = PH_LABEL_LEN;
      end
      PH_QTYPE: begin
        qtype_acc = {qtype_acc[7:0], b};
        qtype_cnt = qtype_cnt + 2'd1;
        if (qtype_cnt >= 2'd2) phase = PH_TRAILER;
      end
      default: ;
    endcase
    if (have)
      pending_results.push_back(dns_result_t'{dkind, dval, 16'h0000, dqe_pkg::STATUS_OK,
                                              ipv6_mode, 1'b0});
    if (p != POS_MAX) pos_cnt = p + 1'b1;
    if (is_last) begin
      qt = 16'h0000;
      if (phase == PH_HDR_SKIP) begin
        st = dqe_pkg::STATUS_SHORT;
      end else if (phase == PH_TRAILER) begin
        st = dqe_pkg::STATUS_OK;
        qt = qtype_acc;
      end else begin
        st = dqe_pkg::STATUS_TRUNC;
      end
      pending_results.push_back(dns_result_t'{dqe_pkg::KIND_SUMMARY, 8'h00, qt, st,
                                              ipv6_mode, 1'b1});
      clear_packet();
    end
  endtask

  // If a byte is still being offered, drops valid and lets a clock edge pass.
  task automatic pkt_idle();
    if (pkt_offering) begin
      pkt_ch.valid <= 1'b0;
      pkt_offering = 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic is_last);
    int gap;
    gap = 0;
    if (idling_on && $urandom_range(0, 3) == 0) gap = pick_gap();
    if (gap > 0 && pkt_offering) begin
      pkt_ch.valid <= 1'b0;
      pkt_offering = 1'b0;
    end
    repeat (gap) @(posedge clk);
    pkt_ch.valid     <= 1'b1;
    pkt_ch.data_byte <= b;
    pkt_ch.last_byte <= is_last;
    pkt_offering = 1'b1;
    do @(posedge clk); while (!pkt_ch.ready);
    predict_extract(b, is_last);
  endtask

  task automatic send_buf(input int from_idx, input int to_idx);
    for (int i = from_idx; i < to_idx; i++)
      send_byte(pkt_buf[i], i == pkt_buf.size() - 1);
  endtask

  task automatic wait_idle();
    pkt_idle();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [dqe_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [7:0] val);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == dqe_pkg::REG_IPV4_OFFSET) cfg_off4 = val;
    else if (idx == dqe_pkg::REG_IPV6_OFFSET) cfg_off6 = val;
  endtask

  // IP header and DNS header of random content, with the version nibble set.
  task automatic start_packet(input logic v6);
    int off;
    logic [3:0] nib;
    off = v6 ? int'(cfg_off6) : int'(cfg_off4);
    pkt_buf.delete();
    for (int i = 0; i < off + 12; i++) pkt_buf.push_back(rand_byte());
    nib = 4'($urandom_range(0, 14));
    if (nib >= dqe_pkg::IPV4_VERSION) nib = nib + 4'd1;
    pkt_buf[0] = {(v6 ? nib : dqe_pkg::IPV4_VERSION), pkt_buf[0][3:0]};
  endtask

  task automatic build_query(input logic v6, input int n_labels, input int max_len,
                             input int tail_len);
    int len;
    start_packet(v6);
    for (int l = 0; l < n_labels; l++) begin
      len = $urandom_range(1, max_len);
      pkt_buf.push_back(len[7:0]);
      for (int i = 0; i < len; i++) pkt_buf.push_back(rand_byte());
    end
    pkt_buf.push_back(8'h00);
    pkt_buf.push_back(rand_byte());
    pkt_buf.push_back(rand_byte());
    for (int i = 0; i < tail_len; i++) pkt_buf.push_back(rand_byte());
  endtask

  task automatic test_directed_extremes();
    write_reg(dqe_pkg::REG_IPV4_OFFSET, 8'h00);
    write_reg(dqe_pkg::REG_IPV6_OFFSET, 8'h00);
    // One-byte packets end inside the header: short status.
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b1);
    // With a zero offset the question sits on the source address bytes.
    pkt_buf.delete();
    pkt_buf.push_back({dqe_pkg::IPV4_VERSION, 4'h5});
    for (int i = 1; i < 12; i++) pkt_buf.push_back((i % 2) ? 8'hFF : 8'h00);
    pkt_buf.push_back(8'd2);
    pkt_buf.push_back(8'h00);
    pkt_buf.push_back(8'hFF);
    pkt_buf.push_back(8'h00);
    pkt_buf.push_back(8'hFF);
    pkt_buf.push_back(8'hFF);
    send_buf(0, pkt_buf.size());
  endtask

  task automatic test_offset_registers();
    write_reg(dqe_pkg::REG_IPV4_OFFSET, 8'hFF);
    write_reg(dqe_pkg::REG_IPV6_OFFSET, 8'hFF);
    // Writes to unused indexes must leave both offsets alone.
    write_reg(REG_SPARE, 8'h00);
    write_reg(REG_TOP, 8'h05);
    build_query(1'b0, 2, 6, 1);
    send_buf(0, pkt_buf.size());
    write_reg(dqe_pkg::REG_IPV4_OFFSET, dqe_pkg::IPV4_OFFSET_RESET);
    write_reg(dqe_pkg::REG_IPV6_OFFSET, dqe_pkg::IPV6_OFFSET_RESET);
    build_query(1'b0, 3, 5, 0);
    send_buf(0, pkt_buf.size());
    build_query(1'b1, 1, 9, 2);
    send_buf(0, pkt_buf.size());
  endtask

  task automatic test_long_labels();
    write_reg(dqe_pkg::REG_IPV4_OFFSET, 8'h00);
    start_packet(1'b0);
    pkt_buf.push_back(8'hFF);
    for (int i = 0; i < 255; i++) pkt_buf.push_back(rand_byte());
    pkt_buf.push_back(8'd3);
    for (int i = 0; i < 3; i++) pkt_buf.push_back(rand_byte());
    pkt_buf.push_back(8'h00);
    pkt_buf.push_back(8'h00);
    pkt_buf.push_back(8'h00);
    send_buf(0, pkt_buf.size());
  endtask

  task automatic test_result_backpressure();
    write_reg(dqe_pkg::REG_IPV6_OFFSET, 8'h00);
    build_query(1'b1, 4, 10, 0);
    hold_req = 1'b1;
    send_buf(0, pkt_buf.size());
  endtask

  task automatic test_sender_pause();
    int half;
    build_query(1'b1, 3, 8, 2);
    half = pkt_buf.size() / 2;
    send_buf(0, half);
    wait_idle();
    send_buf(half, pkt_buf.size());
  endtask

  task automatic test_random_traffic();
    int sent;
    int pick;
    int cut;
    logic v6;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 4) == 0) begin
        write_reg(dqe_pkg::REG_IPV4_OFFSET, pick_offset());
        write_reg(dqe_pkg::REG_IPV6_OFFSET, pick_offset());
      end
      idling_on = ($urandom_range(0, 3) != 0);
      pick = $urandom_range(0, 99);
      v6 = 1'($urandom_range(0, 1));
      if (pick < 85) begin
        build_query(v6, $urandom_range(1, 4), ($urandom_range(0, 7) == 0) ? 40 : 12,
                    $urandom_range(0, 3));
        // Cut some packets short to end inside the header, name, type or trailer.
        if (pick >= 70) begin
          cut = $urandom_range(1, pkt_buf.size() - 1);
          while (pkt_buf.size() > cut) void'(pkt_buf.pop_back());
        end
      end else begin
        pkt_buf.delete();
        repeat ($urandom_range(1, 24)) pkt_buf.push_back(rand_byte());
      end
      sent += pkt_buf.size();
      send_buf(0, pkt_buf.size());
    end
    idling_on = 1'b1;
  endtask

  initial begin : drive_result_ready
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        res_ch.ready <= 1'b0;
        for (int n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        res_ch.ready <= 1'b0;
        repeat (pick_gap()) @(posedge clk);
      end else begin
        res_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin : check_results
    dns_result_t got;
    dns_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      got = dns_result_t'{res_ch.kind, res_ch.value, res_ch.qtype, res_ch.status,
                          res_ch.is_ipv6, res_ch.packet_done};
      if (pending_results.size() == 0) begin
        if (fail_count < REPORT_MAX) begin
          $write("unexpected result: kind=%0d value=%02h qtype=%04h",
                 got.kind, got.value, got.qtype);
          $display(" status=%0d v6=%0b done=%0b", got.status, got.is_ipv6,
                   got.packet_done);
        end
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          if (fail_count < REPORT_MAX) begin
            $write("result differs: expected kind=%0d value=%02h qtype=%04h status=%0d",
                   want.kind, want.value, want.qtype, want.status);
            $write(" v6=%0b done=%0b, got kind=%0d value=%02h qtype=%04h",
                   want.is_ipv6, want.packet_done, got.kind, got.value, got.qtype);
            $display(" status=%0d v6=%0b done=%0b", got.status, got.is_ipv6,
                     got.packet_done);
          end
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("dns_question_extractor_core: mismatch");
      $finish;
    end
  end

  initial begin : run_tests
    pkt_ch.valid     <= 1'b0;
    pkt_ch.data_byte <= 8'h00;
    pkt_ch.last_byte <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.index     <= '0;
    cfg_ch.data      <= 8'h00;
    cfg_off4 = dqe_pkg::IPV4_OFFSET_RESET;
    cfg_off6 = dqe_pkg::IPV6_OFFSET_RESET;
    clear_packet();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_extremes();
    test_offset_registers();
    test_long_labels();
    test_result_backpressure();
    test_sender_pause();
    test_random_traffic();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results.size() == 0)
      $display("dns_question_extractor_core: match");
    else
      $display("dns_question_extractor_core: mismatch");
    $finish;
  end

endmodule
